// ===== src/fpr_pkg.sv =====
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared widths, register indexes and link types for the frequency-based
// page replacement unit.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int COUNT_W    = 16;
  localparam int STAMP_W    = 32;
  localparam int FAULT_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 2'd1;

  localparam logic POLICY_LFU = 1'b0;
  localparam logic POLICY_MFU = 1'b1;

  // Flags carried along the search chain
  typedef struct packed {
    logic found;      // page resident in an earlier frame
    logic empty;      // earlier active frame is empty
    logic have_best;  // a victim candidate has been picked
  } scan_flags_t;

  // Table write broadcast to all cells
  typedef struct packed {
    logic en;
    logic hit;        // 1: bump count, 0: load new page
  } wr_cmd_t;

endpackage

// ===== src/fpr_cell.sv =====
// ----------------------------------------------------------------------------
// fpr_cell
// One frame of the table plus one stage of the search chain: hit match,
// first empty frame and best victim so far, registered toward the next cell.
// ----------------------------------------------------------------------------
module fpr_cell import fpr_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16,
  parameter int INDEX      = 0,
  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 active,
  input  logic                 mode,
  input  logic [PAGE_BITS-1:0] srch_page,
  // chain input
  input  scan_flags_t          flags_in,
  input  logic [IDX_W-1:0]     found_idx_in,
  input  logic [IDX_W-1:0]     empty_idx_in,
  input  logic [IDX_W-1:0]     best_idx_in,
  input  logic [COUNT_W-1:0]   best_count_in,
  input  logic [STAMP_W-1:0]   best_stamp_in,
  input  logic [PAGE_BITS-1:0] best_page_in,
  // chain output
  output scan_flags_t          flags_out,
  output logic [IDX_W-1:0]     found_idx_out,
  output logic [IDX_W-1:0]     empty_idx_out,
  output logic [IDX_W-1:0]     best_idx_out,
  output logic [COUNT_W-1:0]   best_count_out,
  output logic [STAMP_W-1:0]   best_stamp_out,
  output logic [PAGE_BITS-1:0] best_page_out,
  // table write
  input  wr_cmd_t              wr,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [PAGE_BITS-1:0] wr_page,
  input  logic [STAMP_W-1:0]   wr_stamp
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [PAGE_BITS-1:0] page;
  logic                 valid;
  logic [COUNT_W-1:0]   count;
  logic [STAMP_W-1:0]   stamp;

  logic match;
  logic is_empty;
  logic cand;
  logic better;
  logic wr_me;

  assign match    = active && valid && (page == srch_page);
  assign is_empty = active && !valid;
  assign cand     = active && valid;
  assign wr_me    = wr.en && (wr_idx == MY_IDX);

  // strict compare: equal count and stamp keep the lower index
  always_comb begin
    if (!flags_in.have_best) begin
      better = 1'b1;
    end else if (count != best_count_in) begin
      better = (mode == POLICY_MFU) ? (count > best_count_in) : (count < best_count_in);
    end else begin
      better = stamp < best_stamp_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_me) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_me) begin
      stamp <= wr_stamp;
      if (wr.hit) begin
        if (count != {COUNT_W{1'b1}}) begin
          count <= COUNT_W'(count + 1'b1);
        end
      end else begin
        page  <= wr_page;
        count <= COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    flags_out.found     <= flags_in.found | match;
    flags_out.empty     <= flags_in.empty | is_empty;
    flags_out.have_best <= flags_in.have_best | cand;
    found_idx_out <= (!flags_in.found && match) ? MY_IDX : found_idx_in;
    empty_idx_out <= (!flags_in.empty && is_empty) ? MY_IDX : empty_idx_in;
    if (cand && better) begin
      best_idx_out   <= MY_IDX;
      best_count_out <= count;
      best_stamp_out <= stamp;
      best_page_out  <= page;
    end else begin
      best_idx_out   <= best_idx_in;
      best_count_out <= best_count_in;
      best_stamp_out <= best_stamp_in;
      best_page_out  <= best_page_in;
    end
  end

endmodule

// ===== src/frequency_page_replacement_unit.sv =====
// ----------------------------------------------------------------------------
// frequency_page_replacement_unit
// LFU / MFU page replacement over a chain of frame cells.
// ----------------------------------------------------------------------------
// The search walks the cell chain one frame per cycle, then the update state
// writes the table and the result; it waits there while an earlier result is
// stalled at the output. A new input item is taken only once the last is done.
// A result waiting at the output does not block the next input item.
// Reset: all frames empty, stamp clock 1, fault total 0, MFU, 16 frames.
// No clearing pass; the block takes items in the cycle after reset.
module frequency_page_replacement_unit import fpr_pkg::*; #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // references
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [15:0]           page_number,
  input  logic                  last_reference,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  hit,
  output logic [3:0]            frame_index,
  output logic                  evicted_valid,
  output logic [15:0]           evicted_page,
  output logic [FAULT_W-1:0]    faults_so_far,
  output logic                  end_of_string
);

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_FRAMES - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE} state_t;

  state_t                state;
  logic [IDX_W-1:0]      scan_cnt;
  logic [PAGE_BITS-1:0]  req_page;
  logic                  req_last;
  logic                  policy_mode;
  logic [4:0]            frames_in_use;
  logic [STAMP_W-1:0]    stamp_clock;
  logic [FAULT_W-1:0]    fault_counter;

  logic [MAX_FRAMES-1:0] active;
  scan_flags_t           link_flags     [MAX_FRAMES+1];
  logic [IDX_W-1:0]      link_found_idx [MAX_FRAMES+1];
  logic [IDX_W-1:0]      link_empty_idx [MAX_FRAMES+1];
  logic [IDX_W-1:0]      link_best_idx  [MAX_FRAMES+1];
  logic [COUNT_W-1:0]    link_best_count[MAX_FRAMES+1];
  logic [STAMP_W-1:0]    link_best_stamp[MAX_FRAMES+1];
  logic [PAGE_BITS-1:0]  link_best_page [MAX_FRAMES+1];

  wr_cmd_t               wr;
  logic [IDX_W-1:0]      slot;
  logic                  ev_valid;
  logic [STAMP_W-1:0]    stamp_next;
  logic [FAULT_W-1:0]    fault_next;
  logic                  out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  // chain seed
  assign link_flags[0]      = '0;
  assign link_found_idx[0]  = '0;
  assign link_empty_idx[0]  = '0;
  assign link_best_idx[0]   = '0;
  assign link_best_count[0] = '0;
  assign link_best_stamp[0] = '0;
  assign link_best_page[0]  = '0;

  for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
    // frame count of zero acts as one
    assign active[g] = (g == 0) || (g < int'(frames_in_use));

    fpr_cell #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .INDEX      (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .active         (active[g]),
      .mode           (policy_mode),
      .srch_page      (req_page),
      .flags_in       (link_flags[g]),
      .found_idx_in   (link_found_idx[g]),
      .empty_idx_in   (link_empty_idx[g]),
      .best_idx_in    (link_best_idx[g]),
      .best_count_in  (link_best_count[g]),
      .best_stamp_in  (link_best_stamp[g]),
      .best_page_in   (link_best_page[g]),
      .flags_out      (link_flags[g+1]),
      .found_idx_out  (link_found_idx[g+1]),
      .empty_idx_out  (link_empty_idx[g+1]),
      .best_idx_out   (link_best_idx[g+1]),
      .best_count_out (link_best_count[g+1]),
      .best_stamp_out (link_best_stamp[g+1]),
      .best_page_out  (link_best_page[g+1]),
      .wr             (wr),
      .wr_idx         (slot),
      .wr_page        (req_page),
      .wr_stamp       (stamp_next)
    );
  end

  // decision from the chain tail
  always_comb begin
    if (link_flags[MAX_FRAMES].found) begin
      slot = link_found_idx[MAX_FRAMES];
    end else if (link_flags[MAX_FRAMES].empty) begin
      slot = link_empty_idx[MAX_FRAMES];
    end else begin
      slot = link_best_idx[MAX_FRAMES];
    end
    ev_valid   = !link_flags[MAX_FRAMES].found && !link_flags[MAX_FRAMES].empty;
    stamp_next = (stamp_clock == {STAMP_W{1'b1}}) ? stamp_clock
                                                  : STAMP_W'(stamp_clock + 1'b1);
    fault_next = (fault_counter == {FAULT_W{1'b1}}) ? fault_counter
                                                    : FAULT_W'(fault_counter + 1'b1);
    wr.en  = (state == ST_UPDATE) && out_free;
    wr.hit = link_flags[MAX_FRAMES].found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy_mode   <= POLICY_MFU;
      frames_in_use <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POLICY_MODE:   policy_mode   <= cfg_data[0];
        REG_FRAMES_IN_USE: frames_in_use <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      scan_cnt      <= '0;
      out_valid     <= 1'b0;
      stamp_clock   <= STAMP_W'(1);
      fault_counter <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req_page <= PAGE_BITS'(page_number);
            req_last <= last_reference;
            scan_cnt <= '0;
            state    <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          scan_cnt <= IDX_W'(scan_cnt + 1'b1);
          if (scan_cnt == LAST_CELL) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (out_free) begin
            stamp_clock   <= stamp_next;
            out_valid     <= 1'b1;
            hit           <= link_flags[MAX_FRAMES].found;
            frame_index   <= 4'(slot);
            evicted_valid <= ev_valid;
            evicted_page  <= ev_valid ? 16'(link_best_page[MAX_FRAMES]) : 16'd0;
            end_of_string <= req_last;
            if (link_flags[MAX_FRAMES].found) begin
              faults_so_far <= fault_counter;
            end else begin
              fault_counter <= fault_next;
              faults_so_far <= fault_next;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/fpr_checker.sv =====
// ----------------------------------------------------------------------------
// fpr_port_assertions
// Port-level checks on the page replacement unit's result stream.
// ----------------------------------------------------------------------------
module fpr_port_assertions (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        hit,
  input logic [3:0]  frame_index,
  input logic        evicted_valid,
  input logic [15:0] evicted_page,
  input logic [31:0] faults_so_far
);

  logic        have_last;
  logic [31:0] last_faults;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_last <= 1'b0;
    end else if (out_valid && out_ready) begin
      have_last   <= 1'b1;
      last_faults <= faults_so_far;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(frame_index)
      && $stable(faults_so_far))
    else $error("result changed while stalled");

  // one item at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken during search");

  a_evict_on_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> !hit)
    else $error("eviction reported on a hit");

  a_no_evict_page: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_page == 16'd0)
    else $error("evicted page nonzero without eviction");

  // fault total steps by one on each fault until it saturates, holds on hits
  a_fault_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && have_last |->
      ((hit || last_faults == 32'hFFFF_FFFF) ? (faults_so_far == last_faults)
                                             : (faults_so_far == last_faults + 32'd1)))
    else $error("fault total out of step");

endmodule

bind frequency_page_replacement_unit fpr_port_assertions u_fpr_port_assertions (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .hit           (hit),
  .frame_index   (frame_index),
  .evicted_valid (evicted_valid),
  .evicted_page  (evicted_page),
  .faults_so_far (faults_so_far)
);

// ===== sim/fpr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpr_checker
// Scoreboard for the page replacement unit. Keeps its own copy of the frame
// table, updated from accepted config writes and reference items, and checks
// every accepted result item field by field in order.
// ----------------------------------------------------------------------------
module fpr_checker import fpr_pkg::*; #(
  parameter int MAX_FRAMES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [15:0]           page_number,
  input  logic                  last_reference,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  hit,
  input  logic [3:0]            frame_index,
  input  logic                  evicted_valid,
  input  logic [15:0]           evicted_page,
  input  logic [FAULT_W-1:0]    faults_so_far,
  input  logic                  end_of_string,
  output int                    refs_in_flight,
  output int                    mismatch_count
);

  typedef struct packed {
    logic               hit;
    logic [3:0]         frame_index;
    logic               evicted_valid;
    logic [15:0]        evicted_page;
    logic [FAULT_W-1:0] faults;
    logic               end_of_string;
  } access_result_t;

  logic [15:0]           tbl_page  [MAX_FRAMES];
  logic                  tbl_valid [MAX_FRAMES];
  logic [COUNT_W-1:0]    tbl_count [MAX_FRAMES];
  logic [STAMP_W-1:0]    tbl_stamp [MAX_FRAMES];
  logic [STAMP_W-1:0]    stamp_clock;
  logic [FAULT_W-1:0]    fault_total;
  logic                  policy;
  logic [CFG_DATA_W-1:0] frames_cfg;

  access_result_t predicted_accesses[$];
  int errors_seen  = 0;
  int results_seen = 0;

  assign mismatch_count = errors_seen;

  task automatic report_mismatch(input string msg);
    // keep the log short if the unit goes badly wrong
    if (errors_seen < 100) $display("[%0t] result %0d: %s", $time, results_seen, msg);
    errors_seen++;
  endtask

  function automatic int active_frames();
    int n;
    n = int'(frames_cfg);
    if (n < 1) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  function automatic logic [STAMP_W-1:0] advance_stamp();
    if (stamp_clock != '1) stamp_clock++;
    return stamp_clock;
  endfunction

  // a better victim than b: count by policy, then older stamp
  function automatic bit outranks(input int a, input int b);
    if (tbl_count[a] != tbl_count[b]) begin
      if (policy == POLICY_LFU) return tbl_count[a] < tbl_count[b];
      return tbl_count[a] > tbl_count[b];
    end
    return tbl_stamp[a] < tbl_stamp[b];
  endfunction

  task automatic resolve_reference(input logic [15:0] pg, input logic last);
    int             n;
    int             slot;
    bit             found;
    bit             vacant;
    access_result_t r;
    n      = active_frames();
    slot   = 0;
    found  = 1'b0;
    vacant = 1'b0;
    r      = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && tbl_valid[i] && tbl_page[i] == pg) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (tbl_count[slot] != '1) tbl_count[slot]++;
      tbl_stamp[slot] = advance_stamp();
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!vacant && !tbl_valid[i]) begin
          slot   = i;
          vacant = 1'b1;
        end
      end
      if (!vacant) begin
        slot = 0;
        for (int i = 1; i < n; i++) if (outranks(i, slot)) slot = i;
        r.evicted_valid = 1'b1;
        r.evicted_page  = tbl_page[slot];
      end
      tbl_page[slot]  = pg;
      tbl_valid[slot] = 1'b1;
      tbl_count[slot] = COUNT_W'(1);
      tbl_stamp[slot] = advance_stamp();
      if (fault_total != '1) fault_total++;
    end
    r.hit           = found;
    r.frame_index   = slot[3:0];
    r.faults        = fault_total;
    r.end_of_string = last;
    predicted_accesses.push_back(r);
  endtask

  always @(posedge clk) begin
    access_result_t got;
    access_result_t want;
    if (rst) begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
        tbl_page[i]  = '0;
        tbl_valid[i] = 1'b0;
        tbl_count[i] = '0;
        tbl_stamp[i] = '0;
      end
      stamp_clock = STAMP_W'(1);
      fault_total = '0;
      policy      = POLICY_MFU;
      frames_cfg  = 5'd16;
      predicted_accesses.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {hit, frame_index, evicted_valid, evicted_page, faults_so_far, end_of_string};
        if (predicted_accesses.size() == 0) begin
          report_mismatch($sformatf("unexpected result item, frame %0d", got.frame_index));
        end else begin
          want = predicted_accesses.pop_front();
          if (got.hit != want.hit)
            report_mismatch($sformatf("hit %0d, expected %0d", got.hit, want.hit));
          if (got.frame_index != want.frame_index)
            report_mismatch($sformatf("frame_index %0d, expected %0d",
                                      got.frame_index, want.frame_index));
          if (got.evicted_valid != want.evicted_valid)
            report_mismatch($sformatf("evicted_valid %0d, expected %0d",
                                      got.evicted_valid, want.evicted_valid));
          if (got.evicted_page != want.evicted_page)
            report_mismatch($sformatf("evicted_page %h, expected %h",
                                      got.evicted_page, want.evicted_page));
          if (got.faults != want.faults)
            report_mismatch($sformatf("faults_so_far %0d, expected %0d",
                                      got.faults, want.faults));
          if (got.end_of_string != want.end_of_string)
            report_mismatch($sformatf("end_of_string %0d, expected %0d",
                                      got.end_of_string, want.end_of_string));
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POLICY_MODE:   policy = cfg_data[0];
          REG_FRAMES_IN_USE: frames_cfg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) resolve_reference(page_number, last_reference);
    end
    refs_in_flight <= predicted_accesses.size();
  end

endmodule

// ===== sim/frequency_page_replacement_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_page_replacement_unit_tb
// Drives reference strings into the page replacement unit under both
// policies and a range of frame counts, with random gaps and back-pressure.
// The checker beside the unit predicts and compares every result item.
// ----------------------------------------------------------------------------
module frequency_page_replacement_unit_tb;
  import fpr_pkg::*;

  localparam int MAX_FRAMES  = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 2 * MAX_FRAMES + 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [15:0]           page_number;
  logic                  last_reference;
  logic                  out_valid;
  logic                  out_ready;
  logic                  hit;
  logic [3:0]            frame_index;
  logic                  evicted_valid;
  logic [15:0]           evicted_page;
  logic [FAULT_W-1:0]    faults_so_far;
  logic                  end_of_string;

  int          refs_in_flight;
  int          mismatch_count;
  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  int          quiet_cycles = 0;
  logic [15:0] ws_base;
  int          ws_span;

  frequency_page_replacement_unit #(
    .MAX_FRAMES(MAX_FRAMES),
    .PAGE_BITS (16)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .last_reference(last_reference),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .faults_so_far (faults_so_far),
    .end_of_string (end_of_string)
  );

  fpr_checker #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .page_number   (page_number),
    .last_reference(last_reference),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .faults_so_far (faults_so_far),
    .end_of_string (end_of_string),
    .refs_in_flight(refs_in_flight),
    .mismatch_count(mismatch_count)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // only called with no reference in flight
  task automatic program_unit(input logic mode, input logic [CFG_DATA_W-1:0] frames);
    cfg_valid <= 1'b1;
    cfg_index <= REG_POLICY_MODE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= REG_FRAMES_IN_USE;
    cfg_data  <= frames;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_ref(input logic [15:0] pg, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    page_number    <= pg;
    last_reference <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold off until every result item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (refs_in_flight != 0) @(posedge clk);
  endtask

  // mostly a small working set so hits and evictions dominate
  function automatic logic [15:0] pick_page();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return 16'($urandom);
    if (roll < 45) return ws_base + 16'($urandom_range(2));
    return ws_base + 16'($urandom_range(ws_span - 1));
  endfunction

  task automatic run_phase(input logic mode, input logic [CFG_DATA_W-1:0] frames,
                           input int idle_pct, input int stall_pct, input int items);
    logic [15:0] pg;
    logic        last;
    tx_idle_pct  = idle_pct;
    rx_stall_pct = stall_pct;
    program_unit(mode, frames);
    ws_base = 16'($urandom);
    ws_span = (frames == 0 ? 1 : frames > MAX_FRAMES ? MAX_FRAMES : int'(frames)) +
              $urandom_range(1, 5);
    for (int k = 0; k < items; k++) begin
      pg   = pick_page();
      last = ($urandom_range(19) == 0);
      send_ref(pg, last);
      if (last) ws_base = 16'($urandom);
      if (k == items / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst            <= 1'b1;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_POLICY_MODE;
    cfg_data       <= '0;
    in_valid       <= 1'b0;
    page_number    <= '0;
    last_reference <= 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // LFU on four frames: fill, hits, then evict with a count tie
    program_unit(POLICY_LFU, 5'd4);
    send_ref(16'h0000, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h1234, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h0000, 1'b0);
    send_ref(16'h5555, 1'b0);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h1234, 1'b1);
    drain();

    // MFU on the same table, end of string does not clear it
    program_unit(POLICY_MFU, 5'd4);
    send_ref(16'h0F0F, 1'b0);
    send_ref(16'hAAAA, 1'b0);
    send_ref(16'h8001, 1'b0);
    send_ref(16'h8001, 1'b1);
    drain();

    // zero frames acts as one; upper frames are kept untouched
    program_unit(POLICY_MFU, 5'd0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'hFFFF, 1'b0);
    send_ref(16'h7FFE, 1'b0);
    drain();

    // oversized count acts as the full table, old frames visible again
    program_unit(POLICY_LFU, 5'd31);
    send_ref(16'h5555, 1'b0);
    send_ref(16'h8001, 1'b0);
    send_ref(16'h0000, 1'b1);
    drain();

    run_phase(POLICY_MFU, 5'd16,  0,  0, 110);
    run_phase(POLICY_LFU, 5'd16, 79,  0, 100);
    run_phase(POLICY_LFU, 5'd3,   0, 79, 100);
    run_phase(POLICY_MFU, 5'd7,  29, 29, 100);
    run_phase(POLICY_LFU, 5'd0,   0,  0,  60);
    run_phase(POLICY_MFU, 5'd31, 79,  0, 100);
    run_phase(POLICY_LFU, 5'd16,  0, 79, 100);
    run_phase(POLICY_MFU, 5'd1,  29, 29,  60);
    run_phase(POLICY_LFU, 5'd9,   0,  0, 100);

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== frequency_page_replacement_unit.f =====
src/fpr_pkg.sv
src/fpr_cell.sv
src/frequency_page_replacement_unit.sv
src/fpr_checker.sv
sim/fpr_checker.sv
sim/frequency_page_replacement_unit_tb.sv
